>>> hw/rtl/spq_pkg.sv
// Package: shared types, defaults and codes for the sorted priority queue.
package spq_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int KEY_WIDTH_DEF = 32;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam logic MODE_ASCEND  = 1'b0;
	localparam logic MODE_DESCEND = 1'b1;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_POP_EMPTY = 2'd1;
	localparam logic [1:0] STAT_PUSH_FULL = 2'd2;

	typedef struct packed {
		logic        command;
		logic [31:0] key_value;
	} spq_in_t;

	typedef struct packed {
		logic [31:0] front_value;
		logic [4:0]  item_count;
		logic        is_empty;
		logic [1:0]  status;
	} spq_out_t;

	typedef struct packed {
		logic push_en;
		logic pop_en;
		logic order_mode;
	} spq_ctrl_t;

endpackage

>>> hw/rtl/spq_cell.sv
// One storage cell of the sorted chain: holds a key, shifts with its neighbors.
module spq_cell #(
	parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF,
	parameter int CNT_W     = 5,
	parameter int IDX       = 0
) (
	input  logic                  clk,
	input  spq_pkg::spq_ctrl_t    ctrl,
	input  logic [KEY_WIDTH-1:0]  key,
	input  logic [CNT_W-1:0]      count,
	input  logic [KEY_WIDTH-1:0]  left_key,
	input  logic                  left_prec,
	input  logic [KEY_WIDTH-1:0]  right_key,
	output logic [KEY_WIDTH-1:0]  cur_key,
	output logic                  prec,
	output logic [KEY_WIDTH-1:0]  nxt_key
);
	import spq_pkg::*;

	logic [KEY_WIDTH-1:0] key_q;
	logic                 occ;
	logic                 at_tail;
	logic                 ahead;
	logic                 hit;

	assign occ     = CNT_W'(IDX) < count;
	assign at_tail = CNT_W'(IDX) == count;
	assign ahead   = (ctrl.order_mode == MODE_DESCEND) ? (key > key_q) : (key < key_q);
	assign hit     = occ && ahead;
	// set once any cell up to this one is passed by the new key
	assign prec    = left_prec || hit;
	assign cur_key = key_q;

	always_comb begin
		nxt_key = key_q;
		if (ctrl.push_en) begin
			if (left_prec)
				nxt_key = left_key;
			else if (hit || at_tail)
				nxt_key = key;
		end else if (ctrl.pop_en) begin
			nxt_key = right_key;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= nxt_key;
	end

endmodule

>>> hw/rtl/sorted_priority_queue_top.sv
// Top level: sorted priority queue built from a chain of key cells.
//
// Takes one push or pop item per clock while in_stall is low. The new key is
// broadcast to every cell, each cell compares it against its own key in
// parallel, and all cells shift or load in the same edge. The result item is
// registered in the output register, or in a one-entry skid stage behind it
// while the output is stalled; the skid stage lets the block take one
// more item while a result is held, after which the input is stalled until
// the output drains. order_mode selects ascending (0) or descending (1)
// service; equal keys leave in arrival order. A pop on an empty queue and a
// push on a full queue change nothing and are flagged in status.
module sorted_priority_queue_top #(
	parameter int DEPTH     = spq_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  spq_pkg::spq_in_t  in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output spq_pkg::spq_out_t out_item,
	input  logic              cfg_we,
	input  logic              cfg_wdata
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic                 order_mode_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_nxt;
	logic                 acc;
	logic                 full;
	logic                 empty;
	logic [KEY_WIDTH-1:0] key_in;
	spq_ctrl_t            ctrl;
	spq_out_t             res;
	spq_out_t             out_q;
	spq_out_t             skid_q;
	logic                 out_valid_q;
	logic                 skid_valid_q;

	logic [KEY_WIDTH-1:0] cell_key [DEPTH];
	logic [KEY_WIDTH-1:0] cell_nxt [DEPTH];
	logic                 cell_prec [DEPTH];

	assign acc   = in_valid && !in_stall;
	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign key_in = KEY_WIDTH'(in_item.key_value);

	assign ctrl.push_en    = acc && (in_item.command == CMD_PUSH) && !full;
	assign ctrl.pop_en     = acc && (in_item.command == CMD_POP) && !empty;
	assign ctrl.order_mode = order_mode_q;

	always_comb begin
		count_nxt = count_q;
		if (ctrl.push_en)
			count_nxt = count_q + CNT_W'(1);
		else if (ctrl.pop_en)
			count_nxt = count_q - CNT_W'(1);
	end

	generate
		for (genvar i = 0; i < DEPTH; i++) begin : g_cell
			logic [KEY_WIDTH-1:0] lk;
			logic                 lp;
			logic [KEY_WIDTH-1:0] rk;
			if (i == 0) begin : g_first
				assign lk = key_in;
				assign lp = 1'b0;
			end else begin : g_mid
				assign lk = cell_key[i-1];
				assign lp = cell_prec[i-1];
			end
			if (i == DEPTH - 1) begin : g_last
				assign rk = '0;
			end else begin : g_inner
				assign rk = cell_key[i+1];
			end
			spq_cell #(
				.KEY_WIDTH (KEY_WIDTH),
				.CNT_W     (CNT_W),
				.IDX       (i)
			) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.key       (key_in),
				.count     (count_q),
				.left_key  (lk),
				.left_prec (lp),
				.right_key (rk),
				.cur_key   (cell_key[i]),
				.prec      (cell_prec[i]),
				.nxt_key   (cell_nxt[i])
			);
		end
	endgenerate

	always_comb begin
		res.front_value = (count_nxt != '0) ? 32'(cell_nxt[0]) : 32'd0;
		res.item_count  = 5'(count_nxt);
		res.is_empty    = count_nxt == '0;
		res.status      = STAT_OK;
		if (in_item.command == CMD_PUSH && full)
			res.status = STAT_PUSH_FULL;
		else if (in_item.command == CMD_POP && empty)
			res.status = STAT_POP_EMPTY;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= MODE_ASCEND;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				order_mode_q <= cfg_wdata;
			count_q <= count_nxt;
			if (!out_valid_q || !out_stall) begin
				out_valid_q  <= skid_valid_q || acc;
				skid_valid_q <= 1'b0;
			end else if (acc) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (acc) begin
			skid_q <= res;
		end
	end

	assign in_stall  = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds an item while output is empty");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push_en |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("push did not add an entry");

	a_bad_op_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && ((in_item.command == CMD_POP && empty) ||
		(in_item.command == CMD_PUSH && full))) |=> $stable(count_q))
		else $error("rejected item changed the count");

endmodule
